// ===== design/scc_pkg.sv =====
// Shared constants and types for the sensor response CRC checker.
// Used by every module in the design folder; depends on nothing else.
package scc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned POS_W    = 3;

    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
    localparam logic [POS_W-1:0]  FRAME_LEN = 3'd6;

    localparam logic [POS_W-1:0] POS_WORD1_HI = 3'd0;
    localparam logic [POS_W-1:0] POS_WORD1_LO = 3'd1;
    localparam logic [POS_W-1:0] POS_CRC1     = 3'd2;
    localparam logic [POS_W-1:0] POS_WORD2_HI = 3'd3;
    localparam logic [POS_W-1:0] POS_WORD2_LO = 3'd4;
    localparam logic [POS_W-1:0] POS_CRC2     = 3'd5;

    typedef struct packed {
        logic [WORD_W-1:0] co2_equivalent;
        logic [WORD_W-1:0] voc_level;
        logic              crc_ok;
    } scc_result_t;

    typedef struct packed {
        logic        last;
        scc_result_t result;
    } scc_step_t;

endpackage

// ===== design/sensor_response_crc_checker.sv =====
// Top level of the sensor response CRC checker: input register, frame
// tracker and result register. Depends on scc_pkg and scc_frame_tracker.
//
// Bytes of a six-byte sensor read response enter one per transfer; each group
// of a 16-bit big-endian word and its CRC-8 (polynomial 0x31, preset 0xFF) is
// checked, and after the sixth byte one result transfer carries both words and
// crc_ok, with the words forced to zero if either CRC failed. frame_start
// realigns the frame and drops any partial one. A byte is accepted every
// cycle while no sixth byte is held (see below); out_valid rises once the last
// byte of a frame has passed from the input register through the final CRC
// comparison into the result register. While a result waits for out_ready, a
// further sixth byte is held in the input register and input transfers stop.
module sensor_response_crc_checker
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [scc_pkg::BYTE_W-1:0] rx_byte,
    input  logic                       frame_start,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [scc_pkg::WORD_W-1:0] co2_equivalent,
    output logic [scc_pkg::WORD_W-1:0] voc_level,
    output logic                       crc_ok
);

    logic                       in_valid_reg;
    logic [scc_pkg::BYTE_W-1:0] rx_byte_reg;
    logic                       frame_start_reg;
    logic                       out_valid_reg;
    scc_pkg::scc_result_t       result_reg;
    scc_pkg::scc_step_t         step_info;
    logic                       step;
    logic                       in_fire;

    assign step     = in_valid_reg && (!step_info.last || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;
    assign in_fire  = in_valid && in_ready;

    scc_frame_tracker u_tracker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .rx_byte     (rx_byte_reg),
        .frame_start (frame_start_reg),
        .step_info   (step_info)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                in_valid_reg <= 1'b0;
            end
            if (step && step_info.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rx_byte_reg     <= rx_byte;
            frame_start_reg <= frame_start;
        end
        if (step && step_info.last)
        begin
            result_reg <= step_info.result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign co2_equivalent = result_reg.co2_equivalent;
    assign voc_level      = result_reg.voc_level;
    assign crc_ok         = result_reg.crc_ok;

endmodule

// ===== design/scc_crc8.sv =====
// One-byte update of the CRC-8 with polynomial 0x31, fully unrolled.
// Depends on scc_pkg for the byte width and the polynomial.
module scc_crc8
(
    input  logic [scc_pkg::BYTE_W-1:0] crc_in,
    input  logic [scc_pkg::BYTE_W-1:0] data,
    output logic [scc_pkg::BYTE_W-1:0] crc_out
);

    always_comb
    begin
        logic [scc_pkg::BYTE_W-1:0] r;
        r = crc_in ^ data;
        for (int k = 0; k < scc_pkg::BYTE_W; k++)
        begin
            if (r[scc_pkg::BYTE_W-1])
            begin
                r = {r[scc_pkg::BYTE_W-2:0], 1'b0} ^ scc_pkg::CRC_POLY;
            end
            else
            begin
                r = {r[scc_pkg::BYTE_W-2:0], 1'b0};
            end
        end
        crc_out = r;
    end

endmodule

// ===== design/scc_frame_tracker.sv =====
// Frame position, running CRC and data word state for the six-byte response.
// Depends on scc_pkg and scc_crc8.
module scc_frame_tracker
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [scc_pkg::BYTE_W-1:0] rx_byte,
    input  logic                       frame_start,
    output scc_pkg::scc_step_t         step_info
);

    logic [scc_pkg::POS_W-1:0]  byte_position_reg, byte_position_next;
    logic [scc_pkg::BYTE_W-1:0] running_crc_reg, running_crc_next;
    logic [scc_pkg::WORD_W-1:0] first_word_reg, first_word_next;
    logic [scc_pkg::WORD_W-1:0] second_word_reg, second_word_next;
    logic                       first_group_good_reg, first_group_good_next;

    logic [scc_pkg::POS_W-1:0]  pos;
    logic [scc_pkg::BYTE_W-1:0] crc_seed;
    logic [scc_pkg::BYTE_W-1:0] crc_fed;
    logic                       frame_good;

    assign pos = (frame_start || byte_position_reg >= scc_pkg::FRAME_LEN)
                 ? scc_pkg::POS_WORD1_HI : byte_position_reg;

    assign crc_seed = (pos == scc_pkg::POS_WORD1_HI || pos == scc_pkg::POS_WORD2_HI)
                      ? scc_pkg::CRC_INIT : running_crc_reg;

    scc_crc8 u_crc8
    (
        .crc_in  (crc_seed),
        .data    (rx_byte),
        .crc_out (crc_fed)
    );

    assign frame_good = first_group_good_reg && (running_crc_reg == rx_byte);

    always_comb
    begin
        byte_position_next    = pos + 3'd1;
        running_crc_next      = running_crc_reg;
        first_word_next       = first_word_reg;
        second_word_next      = second_word_reg;
        first_group_good_next = first_group_good_reg;
        case (pos)
            scc_pkg::POS_WORD1_HI:
            begin
                running_crc_next = crc_fed;
                first_word_next  = {rx_byte, 8'h00};
            end
            scc_pkg::POS_WORD1_LO:
            begin
                running_crc_next = crc_fed;
                first_word_next  = {first_word_reg[15:8], rx_byte};
            end
            scc_pkg::POS_CRC1:
            begin
                first_group_good_next = (running_crc_reg == rx_byte);
                running_crc_next      = scc_pkg::CRC_INIT;
            end
            scc_pkg::POS_WORD2_HI:
            begin
                running_crc_next = crc_fed;
                second_word_next = {rx_byte, 8'h00};
            end
            scc_pkg::POS_WORD2_LO:
            begin
                running_crc_next = crc_fed;
                second_word_next = {second_word_reg[15:8], rx_byte};
            end
            default:
            begin
                running_crc_next   = scc_pkg::CRC_INIT;
                byte_position_next = scc_pkg::POS_WORD1_HI;
            end
        endcase
    end

    always_comb
    begin
        step_info.last                  = (pos == scc_pkg::POS_CRC2);
        step_info.result.co2_equivalent = frame_good ? first_word_reg : 16'h0000;
        step_info.result.voc_level      = frame_good ? second_word_reg : 16'h0000;
        step_info.result.crc_ok         = frame_good;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg    <= scc_pkg::POS_WORD1_HI;
            running_crc_reg      <= scc_pkg::CRC_INIT;
            first_word_reg       <= '0;
            second_word_reg      <= '0;
            first_group_good_reg <= 1'b0;
        end
        else if (step)
        begin
            byte_position_reg    <= byte_position_next;
            running_crc_reg      <= running_crc_next;
            first_word_reg       <= first_word_next;
            second_word_reg      <= second_word_next;
            first_group_good_reg <= first_group_good_next;
        end
    end

endmodule
